### design/ttsp_pkg.sv
package ttsp_pkg;

    localparam int SIZE_W   = 16;
    localparam int EDGE_W   = 14;
    localparam int COUNT_W  = 7;
    localparam int PADDED_W = 17;
    localparam int LOG2_W   = 4;
    localparam int SCAN_W   = EDGE_W + 1;
    localparam int PROD_W   = SIZE_W + EDGE_W;

    localparam logic [LOG2_W-1:0]   LOG2_LOW   = 4'd10;
    localparam logic [LOG2_W-1:0]   LOG2_HIGH  = 4'd13;
    localparam logic [LOG2_W-1:0]   LOG2_RESET = 4'd11;
    localparam logic [COUNT_W-1:0]  COUNT_MAX  = 7'd127;
    localparam logic [PADDED_W-1:0] PADDED_MAX = 17'h1FFFF;
    localparam logic [3:0]          DIV_LAST_BIT = 4'd15;

    typedef enum logic [5:0] {
        ST_IDLE   = 6'b000001,
        ST_SEARCH = 6'b000010,
        ST_DIVIDE = 6'b000100,
        ST_LAST   = 6'b001000,
        ST_MULT   = 6'b010000,
        ST_ADD    = 6'b100000
    } state_t;

endpackage

### design/texture_tile_size_planner.sv
// Texture tile size planner.
// Input channel: in_valid / in_ready with bitmap_size, one image edge in pixels.
// Output channel: out_valid / out_ready with base_size, base_count, last_size,
// tiling and padded_size, one result per request.
// Configuration: cfg_wr_en / cfg_wr_data write tex_max_log2;
// write it only while no request is in flight.
// Steps: a doubling scan of one candidate edge per cycle, then for tiled
// edges a restoring divider that retires one quotient bit per cycle and,
// when the division leaves a remainder, a second doubling scan for the
// last tile, then a multiply step and an add step. One request is worked
// on at a time; in_ready is high whenever the engine is idle, also while a
// finished result waits in the output register.
// When out_ready stays low the result holds; a following request runs and
// then waits in its final step until the output register is free.
// Reset clears the engine and the output valid and sets tex_max_log2 to 11.
module texture_tile_size_planner #(
    parameter int TEX_MIN_EDGE      = 64,
    parameter int SINGLE_TILE_LIMIT = 1024,
    parameter int TILE_OVERLAP      = 16
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            cfg_wr_en,
    input  logic [ttsp_pkg::LOG2_W-1:0]     cfg_wr_data,
    input  logic                            in_valid,
    output logic                            in_ready,
    input  logic [ttsp_pkg::SIZE_W-1:0]     bitmap_size,
    output logic                            out_valid,
    input  logic                            out_ready,
    output logic [ttsp_pkg::EDGE_W-1:0]     base_size,
    output logic [ttsp_pkg::COUNT_W-1:0]    base_count,
    output logic [ttsp_pkg::EDGE_W-1:0]     last_size,
    output logic                            tiling,
    output logic [ttsp_pkg::PADDED_W-1:0]   padded_size
);

    localparam int SW = ttsp_pkg::SCAN_W;
    localparam int EW = ttsp_pkg::EDGE_W;
    localparam int ZW = ttsp_pkg::SIZE_W;
    localparam int PW = ttsp_pkg::PROD_W;

    localparam logic [SW-1:0] MIN_EDGE_C = SW'(TEX_MIN_EDGE);
    localparam logic [SW-1:0] LIMIT_C    = SW'(SINGLE_TILE_LIMIT);
    localparam logic [SW-1:0] OVERLAP_C  = SW'(TILE_OVERLAP);

    ttsp_pkg::state_t state_reg, state_next;

    logic [ttsp_pkg::LOG2_W-1:0] lg_reg;
    logic [ZW-1:0] size_reg, size_next;
    logic [SW-1:0] scan_reg, scan_next;
    logic [EW-1:0] base_reg, base_next;
    logic [EW-1:0] last_reg, last_next;
    logic          tiling_reg, tiling_next;
    logic [EW-1:0] step_reg, step_next;
    logic [EW-1:0] rem_reg, rem_next;
    logic [ZW-1:0] quo_reg, quo_next;
    logic [3:0]    bit_reg, bit_next;
    logic [ZW-1:0] count_reg, count_next;
    logic [PW-1:0] prod_reg, prod_next;

    logic                               out_valid_reg, out_valid_next;
    logic [EW-1:0]                      base_size_reg, base_size_next;
    logic [ttsp_pkg::COUNT_W-1:0]       base_count_reg, base_count_next;
    logic [EW-1:0]                      last_size_reg, last_size_next;
    logic                               tiling_out_reg, tiling_out_next;
    logic [ttsp_pkg::PADDED_W-1:0]      padded_reg, padded_next;

    logic [ttsp_pkg::LOG2_W-1:0] lg_clamped;
    logic [EW-1:0]               max_edge;
    logic [EW-1:0]               tile_base;
    logic [EW-1:0]               tile_step;
    logic                        scan_found;
    logic [ZW-1:0]               three_quarters;
    logic [SW-1:0]               div_shifted;
    logic [SW:0]                 div_diff;
    logic [EW-1:0]               div_rem;
    logic [ZW-1:0]               div_quo;
    logic [PW:0]                 padded_sum;
    logic                        out_free;

    always_comb
    begin
        priority if (lg_reg < ttsp_pkg::LOG2_LOW)
            lg_clamped = ttsp_pkg::LOG2_LOW;
        else if (lg_reg > ttsp_pkg::LOG2_HIGH)
            lg_clamped = ttsp_pkg::LOG2_HIGH;
        else
            lg_clamped = lg_reg;
    end

    assign max_edge       = EW'(1) << lg_clamped;
    assign scan_found     = (scan_reg <= {1'b0, max_edge}) && (size_reg <= ZW'(scan_reg));
    assign three_quarters = ZW'(scan_reg >> 1) + ZW'(scan_reg >> 2);
    // Base tile: half the power that holds the edge, else the largest edge.
    assign tile_base      = scan_found ? scan_reg[SW-1:1] : max_edge;
    assign tile_step      = ({1'b0, tile_base} > OVERLAP_C)
                            ? EW'({1'b0, tile_base} - OVERLAP_C) : EW'(1);

    // One restoring-division bit per cycle.
    assign div_shifted = {rem_reg, quo_reg[ZW-1]};
    assign div_diff    = {1'b0, div_shifted} - {2'b00, step_reg};
    assign div_rem     = div_diff[SW] ? div_shifted[EW-1:0] : div_diff[EW-1:0];
    assign div_quo     = {quo_reg[ZW-2:0], ~div_diff[SW]};

    assign padded_sum  = {1'b0, prod_reg} + (PW+1)'(last_reg);
    assign out_free    = !out_valid_reg || out_ready;

    always_comb
    begin
        state_next      = state_reg;
        size_next       = size_reg;
        scan_next       = scan_reg;
        base_next       = base_reg;
        last_next       = last_reg;
        tiling_next     = tiling_reg;
        step_next       = step_reg;
        rem_next        = rem_reg;
        quo_next        = quo_reg;
        bit_next        = bit_reg;
        count_next      = count_reg;
        prod_next       = prod_reg;
        out_valid_next  = out_valid_reg && !out_ready;
        base_size_next  = base_size_reg;
        base_count_next = base_count_reg;
        last_size_next  = last_size_reg;
        tiling_out_next = tiling_out_reg;
        padded_next     = padded_reg;

        unique case (state_reg)
            ttsp_pkg::ST_IDLE:
            begin
                if (in_valid)
                begin
                    size_next  = bitmap_size;
                    scan_next  = MIN_EDGE_C;
                    state_next = ttsp_pkg::ST_SEARCH;
                end
            end
            ttsp_pkg::ST_SEARCH:
            begin
                if (scan_found && ((scan_reg <= LIMIT_C) || (size_reg > three_quarters)))
                begin
                    base_next   = scan_reg[EW-1:0];
                    last_next   = scan_reg[EW-1:0];
                    count_next  = '0;
                    tiling_next = 1'b0;
                    state_next  = ttsp_pkg::ST_MULT;
                end
                else if (scan_found || (scan_reg > {1'b0, max_edge}))
                begin
                    base_next   = tile_base;
                    step_next   = tile_step;
                    tiling_next = 1'b1;
                    rem_next    = '0;
                    quo_next    = size_reg;
                    bit_next    = ttsp_pkg::DIV_LAST_BIT;
                    state_next  = ttsp_pkg::ST_DIVIDE;
                end
                else
                begin
                    scan_next = scan_reg << 1;
                end
            end
            ttsp_pkg::ST_DIVIDE:
            begin
                rem_next = div_rem;
                quo_next = div_quo;
                bit_next = bit_reg - 4'd1;
                if (bit_reg == '0)
                begin
                    if (div_rem == '0)
                    begin
                        // Exact fit: fold the final full tile into the last one.
                        count_next = (div_quo == '0) ? '0 : div_quo - ZW'(1);
                        last_next  = step_reg;
                        state_next = ttsp_pkg::ST_MULT;
                    end
                    else
                    begin
                        count_next = div_quo;
                        last_next  = base_reg;
                        scan_next  = OVERLAP_C;
                        state_next = ttsp_pkg::ST_LAST;
                    end
                end
            end
            ttsp_pkg::ST_LAST:
            begin
                if (scan_reg > {1'b0, base_reg})
                    state_next = ttsp_pkg::ST_MULT;
                else if ({1'b0, rem_reg} <= scan_reg)
                begin
                    last_next  = scan_reg[EW-1:0];
                    state_next = ttsp_pkg::ST_MULT;
                end
                else
                    scan_next = scan_reg << 1;
            end
            ttsp_pkg::ST_MULT:
            begin
                prod_next  = {{EW{1'b0}}, count_reg} * {{ZW{1'b0}}, base_reg};
                state_next = ttsp_pkg::ST_ADD;
            end
            ttsp_pkg::ST_ADD:
            begin
                // Hold until the output register is free.
                if (out_free)
                begin
                    out_valid_next  = 1'b1;
                    base_size_next  = base_reg;
                    last_size_next  = last_reg;
                    tiling_out_next = tiling_reg;
                    base_count_next = (count_reg > ZW'(ttsp_pkg::COUNT_MAX))
                                      ? ttsp_pkg::COUNT_MAX
                                      : count_reg[ttsp_pkg::COUNT_W-1:0];
                    padded_next     = (padded_sum > (PW+1)'(ttsp_pkg::PADDED_MAX))
                                      ? ttsp_pkg::PADDED_MAX
                                      : padded_sum[ttsp_pkg::PADDED_W-1:0];
                    state_next      = ttsp_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = ttsp_pkg::ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ttsp_pkg::ST_IDLE;
            out_valid_reg <= 1'b0;
            lg_reg        <= ttsp_pkg::LOG2_RESET;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
            if (cfg_wr_en)
                lg_reg <= cfg_wr_data;
        end
    end

    always_ff @(posedge clk)
    begin
        size_reg       <= size_next;
        scan_reg       <= scan_next;
        base_reg       <= base_next;
        last_reg       <= last_next;
        tiling_reg     <= tiling_next;
        step_reg       <= step_next;
        rem_reg        <= rem_next;
        quo_reg        <= quo_next;
        bit_reg        <= bit_next;
        count_reg      <= count_next;
        prod_reg       <= prod_next;
        base_size_reg  <= base_size_next;
        base_count_reg <= base_count_next;
        last_size_reg  <= last_size_next;
        tiling_out_reg <= tiling_out_next;
        padded_reg     <= padded_next;
    end

    assign in_ready    = (state_reg == ttsp_pkg::ST_IDLE);
    assign out_valid   = out_valid_reg;
    assign base_size   = base_size_reg;
    assign base_count  = base_count_reg;
    assign last_size   = last_size_reg;
    assign tiling      = tiling_out_reg;
    assign padded_size = padded_reg;

endmodule

### tb/tb.sv
module tb;

    localparam int TEX_MIN_EDGE      = 64;
    localparam int SINGLE_TILE_LIMIT = 1024;
    localparam int TILE_OVERLAP      = 16;
    localparam int CYCLE_LIMIT       = 500000;
    localparam int HOLD_CYCLES       = 300;
    localparam int SETTLE_CYCLES     = 40;
    localparam int PHASE_REQUESTS    = 150;

    typedef struct {
        logic [ttsp_pkg::SIZE_W-1:0]   size;
        logic [ttsp_pkg::EDGE_W-1:0]   base;
        logic [ttsp_pkg::COUNT_W-1:0]  count;
        logic [ttsp_pkg::EDGE_W-1:0]   last;
        logic                          tiled;
        logic [ttsp_pkg::PADDED_W-1:0] padded;
    } tile_plan_t;

    logic                          clk = 1'b0;
    logic                          rst_n = 1'b0;
    logic                          cfg_wr_en = 1'b0;
    logic [ttsp_pkg::LOG2_W-1:0]   cfg_wr_data = '0;
    logic                          in_valid = 1'b0;
    logic                          in_ready;
    logic [ttsp_pkg::SIZE_W-1:0]   bitmap_size = '0;
    logic                          out_valid;
    logic                          out_ready = 1'b0;
    logic [ttsp_pkg::EDGE_W-1:0]   base_size;
    logic [ttsp_pkg::COUNT_W-1:0]  base_count;
    logic [ttsp_pkg::EDGE_W-1:0]   last_size;
    logic                          tiling;
    logic [ttsp_pkg::PADDED_W-1:0] padded_size;

    tile_plan_t                    planned_q[$];
    tile_plan_t                    head_plan;
    logic [ttsp_pkg::LOG2_W-1:0]   max_log2_cfg = ttsp_pkg::LOG2_RESET;
    int                            mismatch_count = 0;
    int                            cycle_count = 0;
    bit                            no_idle = 1'b0;
    bit                            hold_req = 1'b0;

    texture_tile_size_planner #(
        .TEX_MIN_EDGE      (TEX_MIN_EDGE),
        .SINGLE_TILE_LIMIT (SINGLE_TILE_LIMIT),
        .TILE_OVERLAP      (TILE_OVERLAP)
    ) DUT (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .in_valid    (in_valid),
        .in_ready    (in_ready),
        .bitmap_size (bitmap_size),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .base_size   (base_size),
        .base_count  (base_count),
        .last_size   (last_size),
        .tiling      (tiling),
        .padded_size (padded_size)
    );

    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    function automatic int unsigned max_edge_of(input logic [ttsp_pkg::LOG2_W-1:0] lg);
        logic [ttsp_pkg::LOG2_W-1:0] l;
        l = lg;
        if (l < ttsp_pkg::LOG2_LOW) l = ttsp_pkg::LOG2_LOW;
        if (l > ttsp_pkg::LOG2_HIGH) l = ttsp_pkg::LOG2_HIGH;
        return 32'd1 << l;
    endfunction

    function automatic tile_plan_t plan_tiles(input logic [ttsp_pkg::SIZE_W-1:0] sz,
                                              input logic [ttsp_pkg::LOG2_W-1:0] lg);
        int unsigned     edge_max, p, q, base, last, step, cnt, rem;
        bit              found, split, last_found;
        longint unsigned pad;
        tile_plan_t      r;
        edge_max = max_edge_of(lg);
        found = 1'b0;
        split = 1'b0;
        base = 0;
        last = 0;
        cnt = 0;
        if (sz <= edge_max)
        begin
            p = TEX_MIN_EDGE;
            while (p <= edge_max && !found)
            begin
                if (sz <= p)
                begin
                    found = 1'b1;
                    // keep one tile when small or when less than a quarter is wasted
                    if (p <= SINGLE_TILE_LIMIT || int'(sz) - int'(p >> 1) > int'(p >> 2))
                    begin
                        base = p;
                        last = p;
                    end
                    else
                    begin
                        base = p >> 1;
                        split = 1'b1;
                    end
                end
                p = p << 1;
            end
        end
        if (!found)
        begin
            base = edge_max;
            split = 1'b1;
        end
        if (split)
        begin
            step = (base > TILE_OVERLAP) ? base - TILE_OVERLAP : 1;
            cnt = sz / step;
            rem = sz % step;
            if (rem == 0)
            begin
                if (cnt > 0) cnt--;
                last = step;
            end
            else
            begin
                last = base;
                last_found = 1'b0;
                q = TILE_OVERLAP;
                while (q <= base && !last_found)
                begin
                    if (rem <= q)
                    begin
                        last = q;
                        last_found = 1'b1;
                    end
                    q = q << 1;
                end
            end
        end
        pad = longint'(cnt) * base + last;
        if (pad > ttsp_pkg::PADDED_MAX) pad = ttsp_pkg::PADDED_MAX;
        if (cnt > ttsp_pkg::COUNT_MAX) cnt = ttsp_pkg::COUNT_MAX;
        r.size   = sz;
        r.base   = ttsp_pkg::EDGE_W'(base);
        r.count  = ttsp_pkg::COUNT_W'(cnt);
        r.last   = ttsp_pkg::EDGE_W'(last);
        r.tiled  = split;
        r.padded = ttsp_pkg::PADDED_W'(pad);
        return r;
    endfunction

    function automatic logic [ttsp_pkg::SIZE_W-1:0] pick_size(
        input logic [ttsp_pkg::LOG2_W-1:0] lg);
        int unsigned edge_max, base, step, k;
        int          v;
        edge_max = max_edge_of(lg);
        case ($urandom_range(0, 5))
            0: v = $urandom_range(0, 65535);
            1: v = $urandom_range(0, edge_max);
            2: v = $urandom_range(edge_max / 4, edge_max);
            3:
            begin
                // land on or next to a whole number of tile steps
                base = $urandom_range(0, 1) ? edge_max : edge_max / 2;
                step = base - TILE_OVERLAP;
                k = $urandom_range(1, 65535 / step);
                v = k * step + $urandom_range(0, 2) - 1;
            end
            4: v = (1 << $urandom_range(0, 15)) + $urandom_range(0, 2) - 1;
            default: v = $urandom_range(edge_max, 65535);
        endcase
        if (v < 0) v = 0;
        if (v > 65535) v = 65535;
        return ttsp_pkg::SIZE_W'(v);
    endfunction

    task automatic report_mismatch(input string msg);
        if (mismatch_count < 100)
            $display("MISMATCH at cycle %0d: %s", cycle_count, msg);
        mismatch_count++;
    endtask

    task automatic check_field(input string name, input int unsigned got,
                               input int unsigned exp_val,
                               input logic [ttsp_pkg::SIZE_W-1:0] sz);
        if (got != exp_val)
            report_mismatch($sformatf("bitmap_size %0d log2 %0d: %s got %0d, expected %0d",
                                      sz, max_log2_cfg, name, got, exp_val));
    endtask

    // Send one request; valid stays high afterward so back-to-back requests need no toggle.
    task automatic send_size(input logic [ttsp_pkg::SIZE_W-1:0] sz);
        int gap;
        gap = no_idle ? 0 : $urandom_range(0, 6);
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        bitmap_size <= sz;
        do @(posedge clk); while (!in_ready);
        planned_q.push_back(plan_tiles(sz, max_log2_cfg));
    endtask

    task automatic drain_results();
        in_valid <= 1'b0;
        while (planned_q.size() != 0) @(posedge clk);
    endtask

    task automatic write_max_log2(input logic [ttsp_pkg::LOG2_W-1:0] v);
        drain_results();
        cfg_wr_en <= 1'b1;
        cfg_wr_data <= v;
        @(posedge clk);
        cfg_wr_en <= 1'b0;
        max_log2_cfg = v;
    endtask

    task automatic test_reset_setting();
        logic [ttsp_pkg::SIZE_W-1:0] sizes[$] = '{16'd0, 16'd1, 16'd63, 16'd64, 16'd65,
                                                 16'd512, 16'd1024, 16'd1025, 16'd1536,
                                                 16'd1537, 16'd2048, 16'd2049, 16'd4064,
                                                 16'd65535};
        foreach (sizes[i]) send_size(sizes[i]);
    endtask

    task automatic test_edge_limits();
        logic [ttsp_pkg::SIZE_W-1:0] top_sizes[$] = '{16'd4097, 16'd6145, 16'd16352,
                                                     16'd65535};
        logic [ttsp_pkg::SIZE_W-1:0] low_sizes[$] = '{16'd1024, 16'd1025, 16'd65535};
        write_max_log2(ttsp_pkg::LOG2_HIGH);
        foreach (top_sizes[i]) send_size(top_sizes[i]);
        write_max_log2(ttsp_pkg::LOG2_LOW);
        foreach (low_sizes[i]) send_size(low_sizes[i]);
    endtask

    task automatic test_random_sizes();
        logic [ttsp_pkg::LOG2_W-1:0] settings[$] = '{4'd10, 4'd13, 4'd0, 4'd15, 4'd12,
                                                    4'd9, 4'd14, 4'd11};
        foreach (settings[i])
        begin
            write_max_log2(settings[i]);
            for (int n = 0; n < PHASE_REQUESTS; n++)
            begin
                // run some stretches with neither side idling
                no_idle = (i % 2 == 1) && n >= 50 && n < 100;
                send_size(pick_size(max_log2_cfg));
            end
            no_idle = 1'b0;
        end
    endtask

    task automatic test_output_stall();
        drain_results();
        hold_req = 1'b1;
        no_idle = 1'b1;
        for (int n = 0; n < 30; n++) send_size(pick_size(max_log2_cfg));
        no_idle = 1'b0;
    endtask

    // Receiver: stall a random number of cycles per result, or hold off long on request.
    initial
    begin
        int stall;
        @(posedge rst_n);
        forever
        begin
            if (hold_req)
            begin
                stall = HOLD_CYCLES;
                hold_req = 1'b0;
            end
            else
                stall = no_idle ? 0 : $urandom_range(0, 6);
            if (stall > 0)
            begin
                out_ready <= 1'b0;
                repeat (stall) @(posedge clk);
            end
            out_ready <= 1'b1;
            do @(posedge clk); while (!out_valid);
        end
    end

    always @(posedge clk)
    begin
        if (out_valid && out_ready)
        begin
            if (planned_q.size() == 0)
                report_mismatch($sformatf("result with nothing expected: base_size %0d",
                                          base_size));
            else
            begin
                head_plan = planned_q.pop_front();
                check_field("base_size", base_size, head_plan.base, head_plan.size);
                check_field("base_count", base_count, head_plan.count, head_plan.size);
                check_field("last_size", last_size, head_plan.last, head_plan.size);
                check_field("tiling", tiling, head_plan.tiled, head_plan.size);
                check_field("padded_size", padded_size, head_plan.padded, head_plan.size);
            end
        end
    end

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("TIMEOUT after %0d cycles, %0d results outstanding",
                     cycle_count, planned_q.size());
            $display("CHECKS FAILED");
            $finish;
        end
    end

    initial
    begin
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        test_reset_setting();
        test_edge_limits();
        test_random_sizes();
        test_output_stall();
        drain_results();
        repeat (SETTLE_CYCLES) @(posedge clk);
        if (mismatch_count == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

endmodule

### sim.f
design/ttsp_pkg.sv
design/texture_tile_size_planner.sv
tb/tb.sv
